// ===== hdl/sorted_array_binary_search_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sorted array binary search block
// Shared helpers that wrap a clocked concurrent assertion with an error report.
// ----------------------------------------------------------------------------
`ifndef SORTED_ARRAY_BINARY_SEARCH_TOP_MACROS_SVH
`define SORTED_ARRAY_BINARY_SEARCH_TOP_MACROS_SVH

// Checked at every rising edge outside of reset.
`define SABS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define SABS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hdl/sabs_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted array binary search package
// Sizes, operation codes, state encoding and word types shared by all modules.
// ----------------------------------------------------------------------------
package sabs_pkg;

  localparam int unsigned DEPTH      = 256;
  localparam int unsigned ADDR_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W      = 9;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned POS_W      = 8;
  localparam int unsigned DATA_W     = 32;

  localparam int unsigned CMDQ_DEPTH = 2;
  localparam int unsigned CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int unsigned CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_SEARCH,
    OP_MISS
  } sabs_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP
  } sabs_state_e;

  typedef struct packed {
    logic                     func;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] value;
  } sabs_in_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } sabs_out_t;

  // For a load, addr is the store index; for a search, the initial upper bound.
  typedef struct packed {
    sabs_op_e                 op;
    logic [ADDR_W-1:0]        addr;
    logic signed [DATA_W-1:0] value;
  } sabs_cmd_t;

endpackage

// ===== hdl/sabs_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// Command queue
// Short register queue that decouples the front stage from the search engine.
// ----------------------------------------------------------------------------
module sabs_cmd_fifo
  import sabs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_valid_i,
  output logic      wr_ready_o,
  input  sabs_cmd_t wr_cmd_i,
  output logic      rd_valid_o,
  input  logic      rd_ready_i,
  output sabs_cmd_t rd_cmd_o
);

  sabs_cmd_t               slot_q [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0]   wptr_q, wptr_d;
  logic [CMDQ_PTR_W-1:0]   rptr_q, rptr_d;
  logic [CMDQ_CNT_W-1:0]   cnt_q, cnt_d;
  logic                    wr_en, rd_en;

  assign wr_ready_o = (cnt_q != CMDQ_CNT_W'(CMDQ_DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_cmd_o   = slot_q[rptr_q];
  assign wr_en      = wr_valid_i && wr_ready_o;
  assign rd_en      = rd_valid_o && rd_ready_i;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (wr_en) begin
      wptr_d = (wptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (rd_en) begin
      rptr_d = (rptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_q[wptr_q] <= wr_cmd_i;
    end
  end

endmodule

// ===== hdl/sabs_front.sv =====
// ----------------------------------------------------------------------------
// Front stage
// Holds the element count register, accepts input words and classifies each
// into a load, a search, or a search that cannot hit.
// ----------------------------------------------------------------------------
module sabs_front
  import sabs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  input  logic             push,
  output logic             full,
  input  sabs_in_t         in_data_i,
  output logic             cmd_valid_o,
  input  logic             cmd_ready_i,
  output sabs_cmd_t        cmd_o
);

  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] count_sat;
  logic             valid_q, valid_d;
  sabs_cmd_t        cmd_q, cmd_d;
  logic             accept;

  assign full        = valid_q && !cmd_ready_i;
  assign accept      = push && !full;
  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

  // Counts beyond the store size are clamped to the store size.
  assign count_sat = (count_q > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : count_q;

  always_comb begin
    cmd_d       = cmd_q;
    cmd_d.value = in_data_i.value;
    if (in_data_i.func == FUNC_LOAD) begin
      cmd_d.op   = OP_LOAD;
      cmd_d.addr = in_data_i.index[ADDR_W-1:0];
    end else if (count_sat == '0) begin
      cmd_d.op   = OP_MISS;
      cmd_d.addr = '0;
    end else begin
      cmd_d.op   = OP_SEARCH;
      cmd_d.addr = ADDR_W'(count_sat - 1'b1);
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

// ===== hdl/sabs_back.sv =====
// ----------------------------------------------------------------------------
// Search engine
// Owns the sorted store, performs loads and runs the iterative probe loop,
// a store read then a compare per probe, into a one-word result register.
// ----------------------------------------------------------------------------
module sabs_back
  import sabs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  output logic      cmd_ready_o,
  input  sabs_cmd_t cmd_i,
  output logic      empty,
  input  logic      pop,
  output sabs_out_t out_data_o
);

  logic [DATA_W-1:0]        store_mem [DEPTH];
  logic signed [DATA_W-1:0] rdata_q;
  logic signed [DATA_W-1:0] target_q;
  logic [ADDR_W-1:0]        low_q, high_q, mid_q;
  logic [ADDR_W:0]          mid_sum;
  logic [ADDR_W-1:0]        mid;

  sabs_state_e state_q, state_d;

  logic      out_valid_q, out_valid_d;
  sabs_out_t out_q;
  logic      out_free;

  logic hit, greater, finish;
  logic mem_we, start, step, res_we;

  assign mid_sum = {1'b0, low_q} + {1'b0, high_q};
  assign mid     = mid_sum[ADDR_W:1];

  assign hit     = (rdata_q == target_q);
  assign greater = (target_q > rdata_q);
  // The range empties when the bound that moves would cross the other one.
  assign finish  = hit || (greater ? (mid_q == high_q) : (mid_q == low_q));

  assign out_free   = !out_valid_q || pop;
  assign empty      = !out_valid_q;
  assign out_data_o = out_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && (cmd_i.op == OP_SEARCH)) begin
          state_d = ST_PROBE;
        end
      end
      ST_PROBE: state_d = ST_CMP;
      ST_CMP: begin
        if (!finish) begin
          state_d = ST_PROBE;
        end else if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready_o = 1'b0;
    mem_we      = 1'b0;
    start       = 1'b0;
    step        = 1'b0;
    res_we      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            OP_LOAD: begin
              cmd_ready_o = 1'b1;
              mem_we      = 1'b1;
            end
            OP_SEARCH: begin
              cmd_ready_o = 1'b1;
              start       = 1'b1;
            end
            OP_MISS: begin
              cmd_ready_o = out_free;
              res_we      = out_free;
            end
            default: cmd_ready_o = 1'b1;
          endcase
        end
      end
      ST_CMP: begin
        if (finish) begin
          res_we = out_free;
        end else begin
          step = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_we) begin
      out_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Store: one write port, one registered read port addressed by the probe.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[cmd_i.addr] <= cmd_i.value;
    end
    rdata_q <= store_mem[mid];
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      target_q <= cmd_i.value;
      low_q    <= '0;
      high_q   <= cmd_i.addr;
    end else if (step) begin
      if (greater) begin
        low_q <= mid_q + 1'b1;
      end else begin
        high_q <= mid_q - 1'b1;
      end
    end
    if (state_q == ST_PROBE) begin
      mid_q <= mid;
    end
    if (res_we) begin
      out_q.found    <= (state_q == ST_CMP) && hit;
      out_q.position <= ((state_q == ST_CMP) && hit) ? POS_W'(mid_q) : '0;
    end
  end

endmodule

// ===== hdl/sorted_array_binary_search_top.sv =====
// ----------------------------------------------------------------------------
// Sorted array binary search
// Loads a store of ascending signed words and answers searches for a target.
//
//   Channel   Handshake          Word
//   input     push / full        in_data_i  (func, index, value)
//   result    empty / pop        out_data_o (found, position)
//   config    cfg_we_i           cfg_wdata_i (element count)
//
// A load is written to the store by the search engine and gives no result.
// A search passes a dispatch step, then a store read and a compare for each
// probe; a zero count answers without probing. The engine handles one word
// at a time. Reset clears the count, the queues and the result register;
// the store keeps its contents. A full result register stalls the engine,
// and the command queue and front register accept words meanwhile until
// they fill, then full holds off the input.
// ----------------------------------------------------------------------------
module sorted_array_binary_search_top
  import sabs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  input  logic             push,
  output logic             full,
  input  sabs_in_t         in_data_i,
  output logic             empty,
  input  logic             pop,
  output sabs_out_t        out_data_o
);

  logic      front_valid, front_ready;
  sabs_cmd_t front_cmd;
  logic      queue_valid, queue_ready;
  sabs_cmd_t queue_cmd;

  sabs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .in_data_i   (in_data_i),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready),
    .cmd_o       (front_cmd)
  );

  sabs_cmd_fifo u_cmd_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (front_valid),
    .wr_ready_o (front_ready),
    .wr_cmd_i   (front_cmd),
    .rd_valid_o (queue_valid),
    .rd_ready_i (queue_ready),
    .rd_cmd_o   (queue_cmd)
  );

  sabs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (queue_valid),
    .cmd_ready_o (queue_ready),
    .cmd_i       (queue_cmd),
    .empty       (empty),
    .pop         (pop),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== hdl/sabs_checker.sv =====
// ----------------------------------------------------------------------------
// Port checker
// Watches the top level ports for result and flow control consistency.
// ----------------------------------------------------------------------------
`include "sorted_array_binary_search_top_macros.svh"

module sabs_checker
  import sabs_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      push,
  input logic      full,
  input sabs_in_t  in_data_i,
  input logic      empty,
  input logic      pop,
  input sabs_out_t out_data_o
);

  logic in_seen;
  assign in_seen = push || in_data_i.func;

  `SABS_ASSERT_ALWAYS(a_empty_in_reset, !rst_ni |-> empty, "result shown during reset")

  `SABS_ASSERT(a_miss_pos_zero, !empty && !out_data_o.found |-> out_data_o.position == '0,
"not-found result with nonzero position")

  `SABS_ASSERT(a_result_held, !empty && !pop |=> !empty && $stable(out_data_o),
"waiting result changed before it was taken")

  // Backpressure can only build up after a new word has come in.
  `SABS_ASSERT(a_full_after_push, $rose(full) |-> $past(push) && $past(in_seen),
"full rose without a preceding push")

endmodule

bind sorted_array_binary_search_top sabs_checker u_sabs_checker (.*);

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Sorted array binary search testbench
// Loads the store with ascending words and sends searches through the queue
// ports, predicting each answer with a local copy of the store and count.
// ----------------------------------------------------------------------------
module testbench;
  import sabs_pkg::*;

  localparam int          CLK_HALF     = 10;
  localparam int          RESET_CYCLES = 11;
  localparam int          SETTLE       = 40;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          SEGMENTS     = 24;
  localparam int          SEG_WORDS    = 55;
  localparam int          HOLD_CYCLES  = 400;
  localparam longint      VAL_MIN      = -64'sd2147483648;
  localparam longint      VAL_MAX      = 64'sd2147483647;

  typedef enum logic {
    ROW_WORD,
    ROW_COUNT
  } row_kind_e;

  typedef struct {
    row_kind_e                kind;
    logic                     func;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] value;
    bit                       typed;
    logic                     found;
    logic [POS_W-1:0]         position;
  } dir_row_t;

  localparam int DIR_ROWS = 22;

  logic             clk_i       = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i    = 1'b0;
  logic [CNT_W-1:0] cfg_wdata_i = '0;
  logic             push        = 1'b0;
  logic             full;
  sabs_in_t         in_data_i   = '0;
  logic             empty;
  logic             pop         = 1'b0;
  sabs_out_t        out_data_o;

  logic signed [DATA_W-1:0] store_copy [DEPTH];
  int unsigned              count_copy;
  sabs_out_t                awaited_answers [$];
  int unsigned              mismatches    = 0;
  int unsigned              answers_seen  = 0;
  int unsigned              cycles        = 0;
  int unsigned              send_idle_pct = 34;
  int unsigned              recv_idle_pct = 68;
  int unsigned              hold_reqs     = 0;
  dir_row_t                 dir_rows [DIR_ROWS];

  sorted_array_binary_search_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .in_data_i   (in_data_i),
    .empty       (empty),
    .pop         (pop),
    .out_data_o  (out_data_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Iterative halving over the first count entries of the store copy.
  function automatic sabs_out_t search_store_copy(input logic signed [DATA_W-1:0] target);
    sabs_out_t ans;
    int        lo;
    int        hi;
    int        mid;
    ans = '0;
    lo  = 0;
    hi  = ((count_copy > DEPTH) ? DEPTH : count_copy) - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (store_copy[mid] == target) begin
        ans.found    = 1'b1;
        ans.position = mid[POS_W-1:0];
        return ans;
      end
      if (target > store_copy[mid]) lo = mid + 1;
      else hi = mid - 1;
    end
    return ans;
  endfunction

  // Offers one word and, once it is taken, records what it should produce.
  task automatic offer_word(input sabs_in_t w, input bit typed, input sabs_out_t typed_ans);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    in_data_i <= w;
    do @(posedge clk_i); while (full);
    if (w.func == FUNC_LOAD) begin
      store_copy[w.index] = w.value;
    end else begin
      awaited_answers.push_back(typed ? typed_ans : search_store_copy(w.value));
    end
  endtask

  task automatic wait_for_answers();
    push <= 1'b0;
    while (awaited_answers.size() != 0) @(posedge clk_i);
  endtask

  // A load leaves no answer behind, so the engine gets extra cycles to settle.
  task automatic write_count(input int unsigned c);
    wait_for_answers();
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= c[CNT_W-1:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    count_copy  = c;
  endtask

  task automatic load_sorted(input int unsigned n);
    longint unsigned step_max;
    longint          cur;
    sabs_in_t        w;
    bit              dense;
    dense = ($urandom_range(0, 2) == 0);
    if (dense) begin
      step_max = 3;
      cur      = longint'($signed($urandom));
      if ($urandom_range(0, 3) == 0) cur = VAL_MIN;
      if (cur > VAL_MAX - longint'(4 * n)) cur = VAL_MAX - longint'(4 * n);
    end else begin
      step_max = 64'd4294967295 / (n + 1);
      cur      = VAL_MIN;
      if ($urandom_range(0, 1) == 0) cur = VAL_MIN + $urandom_range(0, step_max - 1);
    end
    for (int unsigned i = 0; i < n; i++) begin
      if (!dense && i == n - 1 && $urandom_range(0, 3) == 0) cur = VAL_MAX;
      w.func  = FUNC_LOAD;
      w.index = i[IDX_W-1:0];
      w.value = cur[DATA_W-1:0];
      offer_word(w, 1'b0, '0);
      cur += $urandom_range(1, step_max);
    end
  endtask

  // Result side: checks at each taken word, then decides the next pop.
  initial begin
    int unsigned hold_left;
    int unsigned hold_taken;
    sabs_out_t   want;
    hold_left  = 0;
    hold_taken = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) begin
        answers_seen++;
        if (awaited_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("answer %0d: none expected, got found=%0b position=%0d",
                     answers_seen, out_data_o.found, out_data_o.position);
        end else begin
          want = awaited_answers.pop_front();
          if (out_data_o.found !== want.found || out_data_o.position !== want.position) begin
            mismatches++;
            if (mismatches <= 10)
              $display("answer %0d: expected found=%0b position=%0d, got found=%0b position=%0d",
                       answers_seen, want.found, want.position,
                       out_data_o.found, out_data_o.position);
          end
        end
      end
      if (hold_reqs != hold_taken) begin
        hold_taken = hold_reqs;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    sabs_in_t                 w;
    sabs_out_t                ans;
    int unsigned              n_eff;
    int unsigned              c;
    int unsigned              r;
    int unsigned              count_picks [8];
    logic signed [DATA_W-1:0] tgt;

    rst_ni <= 1'b0;
    count_picks = '{0, 1, 2, 3, 255, 256, 300, 511};
    // The store holds unknown words after reset; only the first row, with a
    // zero count, may search before the probed entries are loaded.
    dir_rows = '{
      '{ROW_WORD,  FUNC_SEARCH, 8'd0,   32'sd0,            1'b1, 1'b0, 8'd0},
      '{ROW_WORD,  FUNC_LOAD,   8'd0,   32'sh8000_0000,    1'b0, 1'b0, 8'd0},
      '{ROW_WORD,  FUNC_LOAD,   8'd1,   -32'sd1,           1'b0, 1'b0, 8'd0},
      '{ROW_WORD,  FUNC_LOAD,   8'd2,   32'sd0,            1'b0, 1'b0, 8'd0},
      '{ROW_WORD,  FUNC_LOAD,   8'd3,   32'sh7FFF_FFFF,    1'b0, 1'b0, 8'd0},
      '{ROW_WORD,  FUNC_LOAD,   8'd255, 32'sh5A5A_A5A5,    1'b0, 1'b0, 8'd0},
      '{ROW_COUNT, FUNC_LOAD,   8'd0,   32'sd4,            1'b0, 1'b0, 8'd0},
      '{ROW_WORD,  FUNC_SEARCH, 8'd255, 32'sh8000_0000,    1'b1, 1'b1, 8'd0},
      '{ROW_WORD,  FUNC_SEARCH, 8'd0,   -32'sd1,           1'b1, 1'b1, 8'd1},
      '{ROW_WORD,  FUNC_SEARCH, 8'd170, 32'sd0,            1'b1, 1'b1, 8'd2},
      '{ROW_WORD,  FUNC_SEARCH, 8'd85,  32'sh7FFF_FFFF,    1'b1, 1'b1, 8'd3},
      '{ROW_WORD,  FUNC_SEARCH, 8'd0,   32'sd1,            1'b1, 1'b0, 8'd0},
      '{ROW_WORD,  FUNC_SEARCH, 8'd0,   -32'sd2,           1'b1, 1'b0, 8'd0},
      '{ROW_COUNT, FUNC_LOAD,   8'd0,   32'sd1,            1'b0, 1'b0, 8'd0},
      '{ROW_WORD,  FUNC_SEARCH, 8'd0,   32'sh8000_0000,    1'b1, 1'b1, 8'd0},
      '{ROW_WORD,  FUNC_SEARCH, 8'd0,   32'sh7FFF_FFFF,    1'b1, 1'b0, 8'd0},
      '{ROW_COUNT, FUNC_LOAD,   8'd0,   32'sd0,            1'b0, 1'b0, 8'd0},
      '{ROW_WORD,  FUNC_SEARCH, 8'd0,   32'sh8000_0000,    1'b1, 1'b0, 8'd0},
      // Breaks the ascending order; the probe sequence is followed anyway.
      '{ROW_WORD,  FUNC_LOAD,   8'd1,   32'sd100,          1'b0, 1'b0, 8'd0},
      '{ROW_COUNT, FUNC_LOAD,   8'd0,   32'sd4,            1'b0, 1'b0, 8'd0},
      '{ROW_WORD,  FUNC_SEARCH, 8'd0,   32'sd0,            1'b0, 1'b0, 8'd0},
      '{ROW_WORD,  FUNC_SEARCH, 8'd0,   32'sd100,          1'b0, 1'b0, 8'd0}
    };

    count_copy = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].kind == ROW_COUNT) begin
        write_count(dir_rows[i].value);
      end else begin
        w.func       = dir_rows[i].func;
        w.index      = dir_rows[i].index;
        w.value      = dir_rows[i].value;
        ans.found    = dir_rows[i].found;
        ans.position = dir_rows[i].position;
        offer_word(w, dir_rows[i].typed, ans);
      end
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < SEGMENTS / 3) begin
        send_idle_pct = 34;
        recv_idle_pct = 68;
      end else if (seg < 2 * SEGMENTS / 3) begin
        send_idle_pct = 68;
        recv_idle_pct = 34;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      if (seg == 0 || seg == SEGMENTS / 2) load_sorted(DEPTH);

      if (seg < 8) c = count_picks[seg];
      else if ($urandom_range(0, 3) == 0) c = $urandom_range(1, 8);
      else c = $urandom_range(0, DEPTH);
      write_count(c);
      n_eff = (c > DEPTH) ? DEPTH : c;

      if (seg > 0 && n_eff > 0 && n_eff <= 64 && $urandom_range(0, 1) == 0)
        load_sorted(n_eff);

      // Results back up behind a stalled receiver until the input stalls.
      if (seg == 2) hold_reqs++;

      for (int k = 0; k < SEG_WORDS; k++) begin
        r = $urandom_range(0, 99);
        w.index = IDX_W'($urandom_range(0, DEPTH - 1));
        if (r < 4) begin
          w.func  = FUNC_LOAD;
          w.value = $urandom;
        end else begin
          r = $urandom_range(0, 99);
          if (n_eff > 0 && r < 60) begin
            tgt = store_copy[$urandom_range(0, n_eff - 1)];
          end else if (n_eff > 0 && r < 80) begin
            tgt = store_copy[$urandom_range(0, n_eff - 1)];
            tgt = $urandom_range(0, 1) ? tgt + 1 : tgt - 1;
          end else if (r < 88) begin
            tgt = $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
          end else begin
            tgt = $urandom;
          end
          w.func  = FUNC_SEARCH;
          w.value = tgt;
        end
        offer_word(w, 1'b0, '0);
        if (seg == 5 && k == SEG_WORDS / 2) wait_for_answers();
      end
    end

    wait_for_answers();
    repeat (SETTLE) @(posedge clk_i);
    if (mismatches == 0 && awaited_answers.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/sabs_pkg.sv
hdl/sabs_cmd_fifo.sv
hdl/sabs_front.sv
hdl/sabs_back.sv
hdl/sorted_array_binary_search_top.sv
hdl/sabs_checker.sv
dv/testbench.sv
